// ===== hw/rtl/bbgi_pkg.sv =====
// bbgi_pkg: shared types and fixed widths for the bounding-box gap interpolator.
// No dependencies; used by bounding_box_gap_interpolator and bbgi_checker.
`default_nettype none

package bbgi_pkg;

	localparam int COORD_W   = 12;  // box coordinate / size width
	localparam int NUM_COORD = 4;   // x, y, w, h
	localparam int GAP_W     = 4;   // segment_gap width
	localparam int STEP_W    = 6;   // step_index width
	localparam int DIFF_W    = COORD_W + 1;  // signed next - prev

	typedef enum logic [1:0] {
		ST_IDLE,  // waiting for start
		ST_DIV,   // per-coordinate step division, one quotient bit a cycle
		ST_UPD    // per-box update, one coordinate a cycle
	} bbgi_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounding_box_gap_interpolator.sv =====
// bounding_box_gap_interpolator: linear fill of a track gap between two boxes.
// Depends on bbgi_pkg (widths, state type).
`default_nettype none

//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------------
//  command   | start in, busy out         | prev_x/y/w/h, next_x/y/w/h, segment_gap
//  result    | box_valid out (strobe)     | box_x/y/w/h, step_index, last
//
//  A command beat is taken on a rising edge with start high and busy low.
//  With G = min(segment_gap, MAX_GAP) and N = (G-1)*TRACK_LEN, the block stays
//  busy while it splits the per-box increment (4 coordinates x 12 quotient
//  bits) and then while each of the N boxes passes the shared compare/subtract
//  unit one coordinate at a time; a result beat follows each box's update.
//  G below 2 yields no beat and busy stays low.
//  Each result beat lasts one cycle; the receiver cannot stall it.
//  arst_n clears the sequencer only; no clearing pass is needed.

module bounding_box_gap_interpolator #(
	parameter int TRACK_LEN = 6,
	parameter int MAX_GAP   = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  prev_x,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  prev_y,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  prev_w,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  prev_h,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  next_x,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  next_y,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  next_w,
	input  wire logic [bbgi_pkg::COORD_W-1:0]  next_h,
	input  wire logic [bbgi_pkg::GAP_W-1:0]    segment_gap,
	output logic                               box_valid,
	output logic [bbgi_pkg::COORD_W-1:0]       box_x,
	output logic [bbgi_pkg::COORD_W-1:0]       box_y,
	output logic [bbgi_pkg::COORD_W-1:0]       box_w,
	output logic [bbgi_pkg::COORD_W-1:0]       box_h,
	output logic [bbgi_pkg::STEP_W-1:0]        step_index,
	output logic                               last
);

	// segment_gap is 4 bits wide, so it can never exceed 15 whatever MAX_GAP says
	localparam int GAP_CAP = (MAX_GAP < 15) ? MAX_GAP : 15;
	localparam int N_MAX   = (GAP_CAP > 1) ? (GAP_CAP - 1) * TRACK_LEN : 0;
	// wide enough for the divisor N+1
	localparam int DW      = $clog2(N_MAX + 2);
	localparam int QB_W    = $clog2(bbgi_pkg::COORD_W);

	localparam logic [bbgi_pkg::GAP_W-1:0] GapCap  = bbgi_pkg::GAP_W'(GAP_CAP);
	localparam logic [QB_W-1:0]            QbitTop = QB_W'(bbgi_pkg::COORD_W - 1);

	// ---------------------------------------------------------------------
	// Scheme: numerator(i) = prev*(N+1) + i*(next-prev). Keep it as
	// quotient q and remainder r against den = N+1, starting at q = prev, r = 0.
	// The increment d = next-prev is split once into floor quotient dq and
	// remainder dr in [0, den); each box then adds them with one carry check.
	// ---------------------------------------------------------------------

	bbgi_pkg::bbgi_state_t state_q, state_d;

	logic [1:0]                        crd_q;     // coordinate in work
	logic [QB_W-1:0]                   qbit_q;    // quotient bit in work
	logic [DW-1:0]                     idx_q;     // boxes emitted so far
	logic [DW-1:0]                     n_q;       // box count N
	logic [DW-1:0]                     den_q;     // N + 1
	logic [DW-1:0]                     rem_q;     // long-division remainder
	logic [bbgi_pkg::COORD_W-1:0]      qacc_q;    // long-division quotient bits
	logic                              valid_q;

	logic [bbgi_pkg::COORD_W-1:0]      q_q   [bbgi_pkg::NUM_COORD];
	logic [DW-1:0]                     r_q   [bbgi_pkg::NUM_COORD];
	logic [bbgi_pkg::DIFF_W-1:0]       dq_q  [bbgi_pkg::NUM_COORD];  // two's complement
	logic [DW-1:0]                     dr_q  [bbgi_pkg::NUM_COORD];
	logic [bbgi_pkg::COORD_W-1:0]      mag_q [bbgi_pkg::NUM_COORD];  // |next - prev|
	logic                              neg_q [bbgi_pkg::NUM_COORD];

	logic [bbgi_pkg::COORD_W-1:0]      prev_v [bbgi_pkg::NUM_COORD];
	logic [bbgi_pkg::COORD_W-1:0]      next_v [bbgi_pkg::NUM_COORD];
	logic [bbgi_pkg::DIFF_W-1:0]       diff_v [bbgi_pkg::NUM_COORD];

	logic [bbgi_pkg::GAP_W-1:0]        gap_sat;
	logic [DW-1:0]                     n_calc;
	logic                              accept;
	logic                              launch;

	// shared compare/subtract unit
	logic [DW:0]                       cs_x;
	logic                              cs_ge;
	logic [DW:0]                       cs_diff;
	logic [DW-1:0]                     cs_y;

	// step-split finalize
	logic [bbgi_pkg::COORD_W-1:0]      fin_quo;
	logic                              fin_rz;
	logic [bbgi_pkg::DIFF_W-1:0]       fin_dq;
	logic [DW-1:0]                     fin_dr;

	// box update
	logic [bbgi_pkg::DIFF_W:0]         qsum;

	assign prev_v[0] = prev_x;
	assign prev_v[1] = prev_y;
	assign prev_v[2] = prev_w;
	assign prev_v[3] = prev_h;
	assign next_v[0] = next_x;
	assign next_v[1] = next_y;
	assign next_v[2] = next_w;
	assign next_v[3] = next_h;

	always_comb begin
		for (int c = 0; c < bbgi_pkg::NUM_COORD; c++) begin
			diff_v[c] = {1'b0, next_v[c]} - {1'b0, prev_v[c]};
		end
	end

	assign gap_sat = (segment_gap > GapCap) ? GapCap : segment_gap;
	assign n_calc  = DW'((32'(gap_sat) - 32'd1) * TRACK_LEN);
	assign accept  = start && (state_q == bbgi_pkg::ST_IDLE);
	// gaps of 0 or 1 segment produce nothing and never go busy
	assign launch  = accept && (gap_sat >= bbgi_pkg::GAP_W'(2));

	// shared unit: x >= den ? x - den : x
	always_comb begin
		if (state_q == bbgi_pkg::ST_DIV) begin
			cs_x = {rem_q, mag_q[crd_q][qbit_q]};
		end else begin
			cs_x = {1'b0, r_q[crd_q]} + {1'b0, dr_q[crd_q]};
		end
		cs_diff = cs_x - {1'b0, den_q};
		cs_ge   = (cs_x >= {1'b0, den_q});
		cs_y    = cs_ge ? cs_diff[DW-1:0] : cs_x[DW-1:0];
	end

	// floor split of a possibly negative increment
	always_comb begin
		fin_quo = {qacc_q[bbgi_pkg::COORD_W-2:0], cs_ge};
		fin_rz  = (cs_y == '0);
		if (!neg_q[crd_q]) begin
			fin_dq = {1'b0, fin_quo};
			fin_dr = cs_y;
		end else if (fin_rz) begin
			fin_dq = -{1'b0, fin_quo};
			fin_dr = '0;
		end else begin
			fin_dq = -{1'b0, fin_quo} - bbgi_pkg::DIFF_W'(1);
			fin_dr = den_q - cs_y;
		end
	end

	// q + dq + carry; the true result always lands in 0..4095
	assign qsum = {2'b00, q_q[crd_q]} + {dq_q[crd_q][bbgi_pkg::DIFF_W-1], dq_q[crd_q]}
		+ {{bbgi_pkg::DIFF_W{1'b0}}, cs_ge};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbgi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		case (state_q)
			bbgi_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (launch) begin
					state_d = bbgi_pkg::ST_DIV;
				end
			end
			bbgi_pkg::ST_DIV: begin
				if (qbit_q == '0 && crd_q == 2'd3) begin
					state_d = bbgi_pkg::ST_UPD;
				end
			end
			bbgi_pkg::ST_UPD: begin
				if (crd_q == 2'd3 && (idx_q + DW'(1)) == n_q) begin
					state_d = bbgi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bbgi_pkg::ST_IDLE;
			end
		endcase
	end

	// control counters and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crd_q   <= '0;
			qbit_q  <= QbitTop;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= (state_q == bbgi_pkg::ST_UPD) && (crd_q == 2'd3);
			if (launch) begin
				crd_q  <= '0;
				qbit_q <= QbitTop;
				idx_q  <= '0;
			end else if (state_q == bbgi_pkg::ST_DIV) begin
				if (qbit_q == '0) begin
					qbit_q <= QbitTop;
					crd_q  <= crd_q + 2'd1;
				end else begin
					qbit_q <= qbit_q - QB_W'(1);
				end
			end else if (state_q == bbgi_pkg::ST_UPD) begin
				crd_q <= crd_q + 2'd1;
				if (crd_q == 2'd3) begin
					idx_q <= idx_q + DW'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (launch) begin
			n_q    <= n_calc;
			den_q  <= n_calc + DW'(1);
			rem_q  <= '0;
			for (int c = 0; c < bbgi_pkg::NUM_COORD; c++) begin
				q_q[c]   <= prev_v[c];
				r_q[c]   <= '0;
				neg_q[c] <= diff_v[c][bbgi_pkg::DIFF_W-1];
				mag_q[c] <= diff_v[c][bbgi_pkg::DIFF_W-1]
					? bbgi_pkg::COORD_W'(-diff_v[c]) : diff_v[c][bbgi_pkg::COORD_W-1:0];
			end
		end else if (state_q == bbgi_pkg::ST_DIV) begin
			qacc_q <= fin_quo;
			if (qbit_q == '0) begin
				rem_q         <= '0;
				dq_q[crd_q]   <= fin_dq;
				dr_q[crd_q]   <= fin_dr;
			end else begin
				rem_q <= cs_y;
			end
		end else if (state_q == bbgi_pkg::ST_UPD) begin
			r_q[crd_q] <= cs_y;
			q_q[crd_q] <= qsum[bbgi_pkg::COORD_W-1:0];
		end
	end

	// result beat: coordinates stay put for the strobe cycle
	assign box_valid  = valid_q;
	assign box_x      = q_q[0];
	assign box_y      = q_q[1];
	assign box_w      = q_q[2];
	assign box_h      = q_q[3];
	assign step_index = bbgi_pkg::STEP_W'(idx_q);
	assign last       = (idx_q == n_q);

endmodule

`default_nettype wire

// ===== hw/rtl/bbgi_checker.sv =====
// bbgi_checker: port-level checks on command/result sequencing of the gap interpolator.
// Depends on bbgi_pkg; bound to bounding_box_gap_interpolator below.
`default_nettype none

module bbgi_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          box_valid,
	input wire logic [bbgi_pkg::STEP_W-1:0]   step_index,
	input wire logic                          last
);

	// a beat always closes work that was running the cycle before
	a_beat_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> $past(busy))
		else $error("result beat without preceding work");

	// more boxes pending keeps the block busy
	a_mid_beat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !last |-> busy)
		else $error("busy dropped before last beat");

	// the last beat releases the command side
	a_last_beat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && last |-> !busy)
		else $error("still busy on last beat");

	// beats are spaced by the per-box update sweep
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |=> !box_valid)
		else $error("result beats in consecutive cycles");

	// no beat shows in the cycle right after a command is taken
	a_fresh_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !box_valid || step_index == bbgi_pkg::STEP_W'(0))
		else $error("beat right after command");

endmodule

bind bounding_box_gap_interpolator bbgi_checker u_bbgi_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.box_valid  (box_valid),
	.step_index (step_index),
	.last       (last)
);

`default_nettype wire

// ===== dv/bbgi_checker.sv =====
`timescale 1ns / 100ps
// bbgi_scoreboard: scoreboard for the bounding-box gap interpolator. Predicts each filled
// box from the accepted command beats and compares the result beats in order.
// Depends on bbgi_pkg for field widths.
module bbgi_scoreboard #(
	parameter int TRACK_LEN = 6,
	parameter int MAX_GAP   = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [bbgi_pkg::COORD_W-1:0]      prev_x,
	input  logic [bbgi_pkg::COORD_W-1:0]      prev_y,
	input  logic [bbgi_pkg::COORD_W-1:0]      prev_w,
	input  logic [bbgi_pkg::COORD_W-1:0]      prev_h,
	input  logic [bbgi_pkg::COORD_W-1:0]      next_x,
	input  logic [bbgi_pkg::COORD_W-1:0]      next_y,
	input  logic [bbgi_pkg::COORD_W-1:0]      next_w,
	input  logic [bbgi_pkg::COORD_W-1:0]      next_h,
	input  logic [bbgi_pkg::GAP_W-1:0]        segment_gap,
	input  logic                              box_valid,
	input  logic [bbgi_pkg::COORD_W-1:0]      box_x,
	input  logic [bbgi_pkg::COORD_W-1:0]      box_y,
	input  logic [bbgi_pkg::COORD_W-1:0]      box_w,
	input  logic [bbgi_pkg::COORD_W-1:0]      box_h,
	input  logic [bbgi_pkg::STEP_W-1:0]       step_index,
	input  logic                              last,
	output int                                fail_count,
	output int                                boxes_pending,
	output int                                boxes_checked
);

	typedef struct packed {
		logic [bbgi_pkg::COORD_W-1:0] x;
		logic [bbgi_pkg::COORD_W-1:0] y;
		logic [bbgi_pkg::COORD_W-1:0] w;
		logic [bbgi_pkg::COORD_W-1:0] h;
		logic [bbgi_pkg::STEP_W-1:0]  step;
		logic                         last;
	} fill_box_t;

	fill_box_t fill_q[$];
	int        n_fail    = 0;
	int        n_checked = 0;
	int        pend_r    = 0;

	assign fail_count    = n_fail;
	assign boxes_checked = n_checked;
	assign boxes_pending = pend_r;

	// Queue every box of one gap: floor of the weighted mean, weights (N+1-i) and i.
	function automatic void queue_gap_fill(
			input logic [bbgi_pkg::NUM_COORD-1:0][bbgi_pkg::COORD_W-1:0] pv,
			input logic [bbgi_pkg::NUM_COORD-1:0][bbgi_pkg::COORD_W-1:0] nv,
			input logic [bbgi_pkg::GAP_W-1:0] gap_in);
		int unsigned g;
		int unsigned n_box;
		int unsigned den;
		int unsigned i;
		int          k;
		logic [bbgi_pkg::NUM_COORD-1:0][bbgi_pkg::COORD_W-1:0] c;
		fill_box_t   b;
		g = (gap_in > MAX_GAP) ? MAX_GAP : gap_in;
		if (g < 2)
			return;
		n_box = (g - 1) * TRACK_LEN;
		den   = n_box + 1;
		for (i = 1; i <= n_box; i++) begin
			for (k = 0; k < bbgi_pkg::NUM_COORD; k++)
				c[k] = bbgi_pkg::COORD_W'((int'(pv[k]) * (den - i) + int'(nv[k]) * i) / den);
			b.x    = c[0];
			b.y    = c[1];
			b.w    = c[2];
			b.h    = c[3];
			b.step = i[bbgi_pkg::STEP_W-1:0];
			b.last = (i == n_box);
			fill_q.insert(fill_q.size(), b);
		end
	endfunction

	always @(posedge clk) begin : scoreboard
		fill_box_t want;
		if (arst_n) begin
			if (box_valid) begin
				if (fill_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("%0t: unexpected box beat x=%0d y=%0d w=%0d h=%0d step=%0d last=%0b",
							$realtime, box_x, box_y, box_w, box_h, step_index, last);
				end else begin
					want = fill_q.pop_front();
					n_checked++;
					if (box_x !== want.x || box_y !== want.y || box_w !== want.w ||
							box_h !== want.h || step_index !== want.step || last !== want.last) begin
						n_fail++;
						if (n_fail <= 10) begin
							$display("%0t: box mismatch exp x=%0d y=%0d w=%0d h=%0d step=%0d last=%0b",
								$realtime, want.x, want.y, want.w, want.h, want.step, want.last);
							$display("%0t:              got x=%0d y=%0d w=%0d h=%0d step=%0d last=%0b",
								$realtime, box_x, box_y, box_w, box_h, step_index, last);
						end
					end
				end
			end
			if (start && !busy)
				queue_gap_fill({prev_h, prev_w, prev_y, prev_x},
					{next_h, next_w, next_y, next_x}, segment_gap);
			pend_r <= fill_q.size();
		end
	end

endmodule

// ===== dv/bounding_box_gap_interpolator_tb.sv =====
`timescale 1ns / 100ps
// bounding_box_gap_interpolator_tb: stimulus and verdict for the gap interpolator.
// Depends on bbgi_pkg, bounding_box_gap_interpolator and bbgi_scoreboard.
module bounding_box_gap_interpolator_tb;

	localparam int TRACK_LEN      = 6;
	localparam int MAX_GAP        = 11;
	localparam int N_RANDOM       = 410;
	// Longest quiet stretch in a clean run: the longest hold-off, or the wait
	// for the first box of a gap. Taken several times over.
	localparam int WATCHDOG_LIMIT = 2000;
	// After the last box the block is already idle; slack so a stray beat is still caught.
	localparam int SETTLE_CYCLES  = 64;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         start       = 1'b0;
	logic [bbgi_pkg::COORD_W-1:0] prev_x      = '0;
	logic [bbgi_pkg::COORD_W-1:0] prev_y      = '0;
	logic [bbgi_pkg::COORD_W-1:0] prev_w      = '0;
	logic [bbgi_pkg::COORD_W-1:0] prev_h      = '0;
	logic [bbgi_pkg::COORD_W-1:0] next_x      = '0;
	logic [bbgi_pkg::COORD_W-1:0] next_y      = '0;
	logic [bbgi_pkg::COORD_W-1:0] next_w      = '0;
	logic [bbgi_pkg::COORD_W-1:0] next_h      = '0;
	logic [bbgi_pkg::GAP_W-1:0]   segment_gap = '0;

	logic                         busy;
	logic                         box_valid;
	logic [bbgi_pkg::COORD_W-1:0] box_x;
	logic [bbgi_pkg::COORD_W-1:0] box_y;
	logic [bbgi_pkg::COORD_W-1:0] box_w;
	logic [bbgi_pkg::COORD_W-1:0] box_h;
	logic [bbgi_pkg::STEP_W-1:0]  step_index;
	logic                         last;

	int fail_count;
	int boxes_pending;
	int boxes_checked;

	// run statistics for the closing summary
	int                                 n_cmds       = 0;
	int                                 n_empty      = 0;
	logic [(1<<bbgi_pkg::GAP_W)-1:0]    gaps_seen    = '0;
	int                                 quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bounding_box_gap_interpolator #(
		.TRACK_LEN (TRACK_LEN),
		.MAX_GAP   (MAX_GAP)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.prev_x      (prev_x),
		.prev_y      (prev_y),
		.prev_w      (prev_w),
		.prev_h      (prev_h),
		.next_x      (next_x),
		.next_y      (next_y),
		.next_w      (next_w),
		.next_h      (next_h),
		.segment_gap (segment_gap),
		.box_valid   (box_valid),
		.box_x       (box_x),
		.box_y       (box_y),
		.box_w       (box_w),
		.box_h       (box_h),
		.step_index  (step_index),
		.last        (last)
	);

	// Scoreboard sits on the same wires as the block and sees every beat.
	bbgi_scoreboard #(
		.TRACK_LEN (TRACK_LEN),
		.MAX_GAP   (MAX_GAP)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.prev_x        (prev_x),
		.prev_y        (prev_y),
		.prev_w        (prev_w),
		.prev_h        (prev_h),
		.next_x        (next_x),
		.next_y        (next_y),
		.next_w        (next_w),
		.next_h        (next_h),
		.segment_gap   (segment_gap),
		.box_valid     (box_valid),
		.box_x         (box_x),
		.box_y         (box_y),
		.box_w         (box_w),
		.box_h         (box_h),
		.step_index    (step_index),
		.last          (last),
		.fail_count    (fail_count),
		.boxes_pending (boxes_pending),
		.boxes_checked (boxes_checked)
	);

	// Watchdog: any command or box beat counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || box_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d boxes outstanding",
				quiet_cycles, boxes_pending);
			$display("bounding_box_gap_interpolator verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Mostly full-range values, with the two rails hit often.
	function automatic logic [bbgi_pkg::COORD_W-1:0] rand_coord();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return bbgi_pkg::COORD_W'($urandom_range((1 << bbgi_pkg::COORD_W) - 1));
	endfunction

	// Mostly real gaps 2..MAX_GAP; some adjacent/zero, some past the saturation point.
	function automatic logic [bbgi_pkg::GAP_W-1:0] rand_gap();
		int unsigned pick;
		pick = $urandom_range(19);
		if (pick < 2)
			return bbgi_pkg::GAP_W'($urandom_range(1));
		if (pick < 4)
			return bbgi_pkg::GAP_W'($urandom_range((1 << bbgi_pkg::GAP_W) - 1, MAX_GAP + 1));
		return bbgi_pkg::GAP_W'($urandom_range(MAX_GAP, 2));
	endfunction

	// Present one command beat and hold it until the block takes it. Called at a
	// rising edge; returns at the edge where the beat was taken, start still high.
	task automatic send_gap_cmd(input logic [bbgi_pkg::COORD_W-1:0] px, py, pw, ph,
			nx, ny, nw, nh, input logic [bbgi_pkg::GAP_W-1:0] g);
		prev_x      <= px;
		prev_y      <= py;
		prev_w      <= pw;
		prev_h      <= ph;
		next_x      <= nx;
		next_y      <= ny;
		next_w      <= nw;
		next_h      <= nh;
		segment_gap <= g;
		start       <= 1'b1;
		// busy read at the edge is its pre-edge value, same as the block sees
		do @(posedge clk); while (busy);
		n_cmds++;
		if (g < 2)
			n_empty++;
		gaps_seen[g] = 1'b1;
	endtask

	// Sender idle: start low, garbage on the payload which must be ignored.
	task automatic hold_off(input int unsigned n_cyc);
		repeat (n_cyc) begin
			start       <= 1'b0;
			prev_x      <= bbgi_pkg::COORD_W'($urandom);
			prev_y      <= bbgi_pkg::COORD_W'($urandom);
			prev_w      <= bbgi_pkg::COORD_W'($urandom);
			prev_h      <= bbgi_pkg::COORD_W'($urandom);
			next_x      <= bbgi_pkg::COORD_W'($urandom);
			next_y      <= bbgi_pkg::COORD_W'($urandom);
			next_w      <= bbgi_pkg::COORD_W'($urandom);
			next_h      <= bbgi_pkg::COORD_W'($urandom);
			segment_gap <= bbgi_pkg::GAP_W'($urandom);
			@(posedge clk);
		end
	endtask

	// Stop sending until every predicted box has come out. The pending count is
	// registered in the checker, so it is read in the cycle after the last command.
	task automatic drain_fills();
		start <= 1'b0;
		do @(posedge clk); while (boxes_pending != 0);
	endtask

	initial begin
		int                           g;
		int                           n;
		logic [bbgi_pkg::COORD_W-1:0] a;
		logic [bbgi_pkg::COORD_W-1:0] b;
		int unsigned                  idle_len;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part -------------------------------------------------------
		// Every gap code 0..15 once: zero and adjacent give nothing, 12..15 saturate
		// to the longest gap. The coordinate pattern rotates through the rails,
		// full-scale ramps both ways, alternating bit patterns and random values.
		for (g = 0; g < (1 << bbgi_pkg::GAP_W); g++) begin
			case (g % 6)
				0: begin a = '0;      b = '0;      end
				1: begin a = '1;      b = '1;      end
				2: begin a = '0;      b = '1;      end
				3: begin a = '1;      b = '0;      end
				4: begin a = 12'hAAA; b = 12'h555; end
				default: begin a = rand_coord(); b = rand_coord(); end
			endcase
			send_gap_cmd(a, b, a, b, b, a, b, a, bbgi_pkg::GAP_W'(g));
		end
		// Longest gap (60 boxes) with mixed per-coordinate ramps and a flat track, then the shortest gap.
		send_gap_cmd('0, '1, 12'd1, 12'd7, '1, '0, 12'd4094, 12'd7,
			bbgi_pkg::GAP_W'(MAX_GAP));
		send_gap_cmd('1, '0, '1, 12'd0, '0, '1, '1, 12'd61, bbgi_pkg::GAP_W'(MAX_GAP));
		a = rand_coord();
		send_gap_cmd(a, a, a, a, a, a, a, a, bbgi_pkg::GAP_W'(MAX_GAP));
		send_gap_cmd(12'h555, 12'hAAA, 12'h001, 12'h800, 12'hAAA, 12'h555, 12'h800, 12'h001,
			bbgi_pkg::GAP_W'(2));

		// All directed fills out before random traffic starts.
		drain_fills();

		// ---- random part ---------------------------------------------------------
		// Hold-offs are short or long so that they land anywhere in the block's
		// divide and update phases. Items 150..229 go back to back, no idling.
		for (n = 0; n < N_RANDOM; n++) begin
			if ((n < 150 || n >= 230) && $urandom_range(99) < 30) begin
				idle_len = ($urandom_range(3) == 0) ? $urandom_range(300, 20)
					: $urandom_range(6, 1);
				hold_off(idle_len);
			end
			send_gap_cmd(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_gap());
			if (n == 300)
				drain_fills();
		end

		// ---- wind down -----------------------------------------------------------
		drain_fills();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d gap commands (%0d with nothing to fill), all gap codes hit: %s",
			n_cmds, n_empty, (gaps_seen == '1) ? "yes" : "no");
		$display("run: %0d predicted boxes compared, %0d failures", boxes_checked,
			fail_count + boxes_pending);
		if (fail_count == 0 && boxes_pending == 0)
			$display("bounding_box_gap_interpolator verification clean");
		else
			$display("bounding_box_gap_interpolator verification failed");
		$finish;
	end

endmodule
